>>> hw/rtl/uf_pkg.sv
// uf_pkg: shared constants and types for the union-find engine
// depends on nothing; used by the interfaces, uf_ctrl and union_find_engine

package uf_pkg;

	// default store depth
	localparam int NODES_DEF = 16;

	// request and response field widths
	localparam int OP_W   = 2;
	localparam int NODE_W = 4;

	// opcodes
	localparam logic [OP_W-1:0] OP_FIND     = 2'd0;
	localparam logic [OP_W-1:0] OP_COMPRESS = 2'd1;
	localparam logic [OP_W-1:0] OP_UNION    = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR    = 2'd3;

	// finished result handed from the controller to the output register
	typedef struct packed {
		logic              valid;
		logic [NODE_W-1:0] root;
	} res_t;

endpackage

>>> hw/rtl/uf_req_if.sv
// uf_req_if: request channel of the union-find engine (opcode and two nodes)
// depends on uf_pkg

interface uf_req_if;
	logic                      valid;
	logic                      ready;
	logic [uf_pkg::OP_W-1:0]   opcode;
	logic [uf_pkg::NODE_W-1:0] node_a;
	logic [uf_pkg::NODE_W-1:0] node_b;

	modport source (output valid, opcode, node_a, node_b, input ready);
	modport sink (input valid, opcode, node_a, node_b, output ready);
endinterface

>>> hw/rtl/uf_rsp_if.sv
// uf_rsp_if: response channel of the union-find engine (root index)
// depends on uf_pkg

interface uf_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [uf_pkg::NODE_W-1:0] root_index;

	modport source (output valid, root_index, input ready);
	modport sink (input valid, root_index, output ready);
endinterface

>>> hw/rtl/union_find_engine.sv
// union_find_engine: top level of the disjoint-set engine
// depends on uf_pkg, uf_req_if, uf_rsp_if, uf_ctrl, uf_mem

// Disjoint-set store of NODES nodes held in one synchronous memory (root
// marker plus parent index per entry). Requests are handled one at a time;
// a walk makes one parent hop per cycle because every hop is one read of the
// single memory read port. Clear rewrites every entry, one per cycle, and
// then answers. After reset the same sweep runs over every entry before the
// first request is taken. The result sits in an output register, so a new
// request is taken while the previous answer waits.

module union_find_engine #(
	parameter int NODES = uf_pkg::NODES_DEF
) (
	input logic    clk,
	input logic    arst_n,
	uf_req_if.sink req,
	uf_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(NODES);
	localparam int ENT_W = IDX_W + 1;

	uf_pkg::res_t              res;
	logic                      res_free;
	logic                      mem_we;
	logic [IDX_W-1:0]          mem_waddr;
	logic [ENT_W-1:0]          mem_wdata;
	logic [IDX_W-1:0]          mem_raddr;
	logic [ENT_W-1:0]          mem_rdata;
	logic                      vld_q;
	logic [uf_pkg::NODE_W-1:0] root_q;

	uf_ctrl #(
		.NODES (NODES),
		.IDX_W (IDX_W),
		.ENT_W (ENT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.res_free  (res_free),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	uf_mem #(
		.DEPTH (NODES),
		.AW    (IDX_W),
		.DW    (ENT_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register
	assign res_free       = !vld_q || rsp.ready;
	assign rsp.valid      = vld_q;
	assign rsp.root_index = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (res_free) begin
			vld_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res.valid) begin
			root_q <= res.root;
		end
	end

endmodule

>>> hw/rtl/uf_mem.sv
// uf_mem: parent link store, one write and one read port, registered read
// no dependencies; a write to the entry being read is forwarded to the read data

module uf_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, write-first on an address match
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/uf_ctrl.sv
// uf_ctrl: sequencer that walks and relinks parent chains, one memory hop a cycle
// depends on uf_pkg, uf_req_if; drives the uf_mem ports

module uf_ctrl #(
	parameter int NODES = uf_pkg::NODES_DEF,
	parameter int IDX_W = $clog2(NODES),
	parameter int ENT_W = IDX_W + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	uf_req_if.sink             req,
	output uf_pkg::res_t       res,
	input  logic               res_free,
	output logic               mem_we,
	output logic [IDX_W-1:0]   mem_waddr,
	output logic [ENT_W-1:0]   mem_wdata,
	output logic [IDX_W-1:0]   mem_raddr,
	input  logic [ENT_W-1:0]   mem_rdata
);

	localparam int HOP_W = $clog2(NODES + 1);

	// sequencer states
	localparam logic [2:0] S_INIT = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_WALK = 3'd2;
	localparam logic [2:0] S_RELA = 3'd3;
	localparam logic [2:0] S_RELB = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]                st_q, st_d;
	logic [IDX_W-1:0]          cur_q, cur_d;
	logic [HOP_W-1:0]          hops_q, hops_d;
	logic [IDX_W-1:0]          clr_q, clr_d;
	logic                      clr_op_q, clr_op_d;
	logic [uf_pkg::OP_W-1:0]   op_q, op_d;
	logic [IDX_W-1:0]          a_q, a_d;
	logic [IDX_W-1:0]          b_q, b_d;
	logic [IDX_W-1:0]          root_q, root_d;

	logic                      req_acc;
	logic                      rd_root;
	logic [IDX_W-1:0]          rd_par;
	logic                      hop_end;
	logic [IDX_W-1:0]          clip_tbl [16];

	// node index reduction table, built at elaboration
	for (genvar v = 0; v < 16; v++) begin : g_clip
		assign clip_tbl[v] = IDX_W'(v % NODES);
	end

	assign req.ready = (st_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;

	// fields of the entry read in the previous cycle
	assign rd_root = mem_rdata[IDX_W];
	assign rd_par  = mem_rdata[IDX_W-1:0];
	assign hop_end = rd_root || (hops_q == HOP_W'(NODES));

	// next-state and memory control
	always_comb begin
		st_d      = st_q;
		cur_d     = cur_q;
		hops_d    = hops_q;
		clr_d     = clr_q;
		clr_op_d  = clr_op_q;
		op_d      = op_q;
		a_d       = a_q;
		b_d       = b_q;
		root_d    = root_q;
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = {1'b0, root_q};
		res.valid = 1'b0;
		res.root  = uf_pkg::NODE_W'(root_q);
		unique case (st_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = {1'b1, {IDX_W{1'b0}}};
				if (clr_q == IDX_W'(NODES - 1)) begin
					st_d = clr_op_q ? S_DONE : S_IDLE;
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end
			S_IDLE: begin
				if (req_acc) begin
					op_d   = req.opcode;
					a_d    = clip_tbl[req.node_a];
					b_d    = clip_tbl[req.node_b];
					cur_d  = clip_tbl[req.node_a];
					hops_d = '0;
					if (req.opcode == uf_pkg::OP_CLEAR) begin
						st_d     = S_INIT;
						clr_d    = '0;
						clr_op_d = 1'b1;
						root_d   = '0;
					end else begin
						st_d = S_WALK;
					end
				end
			end
			S_WALK: begin
				if (hop_end) begin
					root_d = cur_q;
					if (op_q == uf_pkg::OP_FIND) begin
						st_d = S_DONE;
					end else begin
						cur_d  = a_q;
						hops_d = '0;
						st_d   = S_RELA;
					end
				end else begin
					cur_d  = rd_par;
					hops_d = hops_q + 1'b1;
				end
			end
			S_RELA: begin
				if (hop_end) begin
					if (op_q == uf_pkg::OP_COMPRESS) begin
						st_d = S_DONE;
					end else begin
						cur_d  = b_q;
						hops_d = '0;
						st_d   = S_RELB;
					end
				end else begin
					mem_we = 1'b1;
					cur_d  = rd_par;
					hops_d = hops_q + 1'b1;
				end
			end
			S_RELB: begin
				if (hop_end) begin
					// old root of node_b joins under the new root
					mem_we = rd_root && (cur_q != root_q);
					st_d   = S_DONE;
				end else begin
					mem_we = 1'b1;
					cur_d  = rd_par;
					hops_d = hops_q + 1'b1;
				end
			end
			S_DONE: begin
				res.valid = 1'b1;
				if (res_free) begin
					st_d = S_IDLE;
				end
			end
			default: begin
				st_d = S_INIT;
			end
		endcase
		mem_raddr = cur_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_INIT;
			clr_q    <= '0;
			clr_op_q <= 1'b0;
			hops_q   <= '0;
		end else begin
			st_q     <= st_d;
			clr_q    <= clr_d;
			clr_op_q <= clr_op_d;
			hops_q   <= hops_d;
		end
	end

	// request payload and walk position
	always_ff @(posedge clk) begin
		cur_q  <= cur_d;
		op_q   <= op_d;
		a_q    <= a_d;
		b_q    <= b_d;
		root_q <= root_d;
	end

`ifndef SYNTHESIS
	// a walk never runs past the hop bound
	a_hops_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hops_q <= HOP_W'(NODES))
		else $error("hop counter beyond node count");

	// a relink never points a node at itself
	a_no_self_link: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && !mem_wdata[IDX_W]) |-> (mem_waddr != mem_wdata[IDX_W-1:0]))
		else $error("node linked to itself");

	// a clear request starts the sweep at entry zero
	a_clear_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.opcode == uf_pkg::OP_CLEAR) |=> (st_q == S_INIT && clr_q == '0))
		else $error("clear did not start sweep");

	// a result is offered only once the sweep or walk has finished
	a_res_state: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> $past(st_q) != S_IDLE)
		else $error("result without a request");
`endif

endmodule

>>> verif/union_find_engine_tb.sv
`timescale 1ns / 1ps
// union_find_engine_tb: self-checking bench for the disjoint-set engine
// keeps its own forest of parent links, predicts every root and checks each response
// depends on uf_pkg, uf_req_if, uf_rsp_if and union_find_engine

module union_find_engine_tb;

	localparam int N              = uf_pkg::NODES_DEF;
	localparam int IDLE_LIMIT     = 2000;
	localparam int DRAIN_CYCLES   = 3 * N + 8;
	localparam int RANDOM_ITEMS   = 1650;
	localparam int REPORT_LIMIT   = 10;

	// one request as accepted, with the root it must answer
	typedef struct {
		logic [uf_pkg::OP_W-1:0]   op;
		logic [uf_pkg::NODE_W-1:0] a;
		logic [uf_pkg::NODE_W-1:0] b;
		logic [uf_pkg::NODE_W-1:0] root;
	} root_expect_t;

	// forest predictor plus the queue of roots still owed by the engine
	class root_scoreboard;
		bit                        is_root [N];
		logic [uf_pkg::NODE_W-1:0] link [N];
		root_expect_t              pending [$];
		int                        failures;

		function new();
			failures = 0;
			make_singletons();
		endfunction

		function void make_singletons();
			for (int i = 0; i < N; i++) begin
				is_root[i] = 1'b1;
				link[i]    = '0;
			end
		endfunction

		// follow parent links, bounded by the node count
		function int chase_root(int n);
			int cur;
			int hops;
			cur  = n;
			hops = 0;
			while (!is_root[cur] && hops < N) begin
				cur = int'(link[cur]) % N;
				hops++;
			end
			return cur;
		endfunction

		// point every non-root node on the path at target, return where it stopped
		function int repoint_path(int n, int target);
			int cur;
			int hops;
			int nxt;
			cur  = n;
			hops = 0;
			while (!is_root[cur] && hops < N) begin
				nxt       = int'(link[cur]) % N;
				link[cur] = uf_pkg::NODE_W'(target);
				cur       = nxt;
				hops++;
			end
			return cur;
		endfunction

		function void note_request(logic [uf_pkg::OP_W-1:0] op,
				logic [uf_pkg::NODE_W-1:0] a, logic [uf_pkg::NODE_W-1:0] b);
			int           ai;
			int           bi;
			int           r;
			int           rb;
			root_expect_t e;
			ai = int'(a) % N;
			bi = int'(b) % N;
			r  = 0;
			case (op)
				uf_pkg::OP_FIND: begin
					r = chase_root(ai);
				end
				uf_pkg::OP_COMPRESS: begin
					r = chase_root(ai);
					void'(repoint_path(ai, r));
				end
				uf_pkg::OP_UNION: begin
					r = chase_root(ai);
					void'(repoint_path(ai, r));
					rb = repoint_path(bi, r);
					if (rb != r && is_root[rb]) begin
						is_root[rb] = 1'b0;
						link[rb]    = uf_pkg::NODE_W'(r);
					end
				end
				default: begin
					make_singletons();
					r = 0;
				end
			endcase
			e.op   = op;
			e.a    = a;
			e.b    = b;
			e.root = uf_pkg::NODE_W'(r);
			pending.push_back(e);
		endfunction

		function void check_root(logic [uf_pkg::NODE_W-1:0] got);
			root_expect_t e;
			if (pending.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected response: root_index %0d with no request owed", got);
			end else begin
				e = pending.pop_front();
				if (got !== e.root) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display("root mismatch: op %0d a %0d b %0d expected %0d got %0d",
							e.op, e.a, e.b, e.root, got);
				end
			end
		endfunction

		function int outstanding();
			return pending.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	uf_req_if req_ch ();
	uf_rsp_if rsp_ch ();

	union_find_engine #(
		.NODES(N)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	root_scoreboard roots = new();
	int             sent = 0;
	bit             req_burst = 1'b0;

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// present one request after a random gap and hold it until taken
	task automatic send_request(input logic [uf_pkg::OP_W-1:0] op,
			input logic [uf_pkg::NODE_W-1:0] a, input logic [uf_pkg::NODE_W-1:0] b);
		int gap;
		if (sent % 100 == 0)
			req_burst = ($urandom_range(0, 3) == 0);
		gap = req_burst ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.opcode <= op;
		req_ch.node_a <= a;
		req_ch.node_b <= b;
		// ready is settled mid-cycle, the next rising edge takes the request
		do @(negedge clk); while (!req_ch.ready);
		@(posedge clk);
		roots.note_request(op, a, b);
		sent++;
	endtask

	// response side: random stalls, checks every accepted root
	initial begin
		int                        gap;
		int                        taken;
		bit                        rsp_burst;
		logic [uf_pkg::NODE_W-1:0] got;
		taken     = 0;
		rsp_burst = 1'b0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken % 64 == 0)
				rsp_burst = ($urandom_range(0, 3) == 0);
			gap = rsp_burst ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			// sample the response mid-cycle, it is taken at the next rising edge
			do @(negedge clk); while (!rsp_ch.valid);
			got = rsp_ch.root_index;
			@(posedge clk);
			roots.check_root(got);
			taken++;
		end
	end

	// watchdog on cycles without any accepted request or response
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(negedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("union_find_engine verification failed");
		$finish;
	end

	// stimulus
	initial begin
		int                      perm [N];
		int                      j;
		int                      tmp;
		int                      len;
		int                      ops;
		int                      r;
		logic [uf_pkg::OP_W-1:0] op;

		arst_n        <= 1'b0;
		req_ch.valid  <= 1'b0;
		req_ch.opcode <= uf_pkg::OP_FIND;
		req_ch.node_a <= '0;
		req_ch.node_b <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: singletons, extremes, a small forest, same-set unions, clear
		send_request(uf_pkg::OP_FIND, 4'd0, 4'd15);
		send_request(uf_pkg::OP_FIND, 4'd15, 4'd0);
		send_request(uf_pkg::OP_COMPRESS, 4'd15, 4'd15);
		send_request(uf_pkg::OP_UNION, 4'd0, 4'd1);
		send_request(uf_pkg::OP_UNION, 4'd2, 4'd3);
		send_request(uf_pkg::OP_UNION, 4'd1, 4'd3);
		send_request(uf_pkg::OP_UNION, 4'd15, 4'd14);
		send_request(uf_pkg::OP_UNION, 4'd14, 4'd0);
		send_request(uf_pkg::OP_FIND, 4'd2, 4'd9);
		send_request(uf_pkg::OP_COMPRESS, 4'd2, 4'd5);
		send_request(uf_pkg::OP_FIND, 4'd2, 4'd0);
		send_request(uf_pkg::OP_UNION, 4'd3, 4'd3);
		send_request(uf_pkg::OP_UNION, 4'd15, 4'd15);
		send_request(uf_pkg::OP_UNION, 4'd0, 4'd2);
		send_request(uf_pkg::OP_UNION, 4'd5, 4'd15);
		send_request(uf_pkg::OP_COMPRESS, 4'd1, 4'd10);
		send_request(uf_pkg::OP_FIND, 4'd14, 4'd15);
		send_request(uf_pkg::OP_CLEAR, 4'd15, 4'd15);
		send_request(uf_pkg::OP_FIND, 4'd1, 4'd0);
		send_request(uf_pkg::OP_UNION, 4'd15, 4'd0);
		send_request(uf_pkg::OP_CLEAR, 4'd0, 4'd0);
		send_request(uf_pkg::OP_FIND, 4'd15, 4'd15);

		// random segments: often a fresh deep chain, then mixed traffic
		while (sent < RANDOM_ITEMS + 22) begin
			if ($urandom_range(0, 2) == 0) begin
				for (int i = 0; i < N; i++)
					perm[i] = i;
				for (int i = N - 1; i > 0; i--) begin
					j       = $urandom_range(0, i);
					tmp     = perm[i];
					perm[i] = perm[j];
					perm[j] = tmp;
				end
				send_request(uf_pkg::OP_CLEAR, uf_pkg::NODE_W'($urandom_range(0, 15)),
					uf_pkg::NODE_W'($urandom_range(0, 15)));
				len = $urandom_range(4, N - 1);
				// each union hangs the previous root below a new node
				for (int k = 0; k < len; k++)
					send_request(uf_pkg::OP_UNION, uf_pkg::NODE_W'(perm[k + 1]),
						uf_pkg::NODE_W'(perm[k]));
			end
			ops = $urandom_range(20, 60);
			for (int k = 0; k < ops; k++) begin
				r = $urandom_range(0, 99);
				if (r < 2)
					op = uf_pkg::OP_CLEAR;
				else if (r < 45)
					op = uf_pkg::OP_UNION;
				else if (r < 72)
					op = uf_pkg::OP_COMPRESS;
				else
					op = uf_pkg::OP_FIND;
				send_request(op, uf_pkg::NODE_W'($urandom_range(0, 15)),
					uf_pkg::NODE_W'($urandom_range(0, 15)));
			end
		end
		req_ch.valid <= 1'b0;

		// drain, then let the engine settle
		while (roots.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (roots.failures == 0 && roots.outstanding() == 0) begin
			$display("union_find_engine verification clean");
		end else begin
			$display("union_find_engine verification failed");
		end
		$finish;
	end

endmodule
